@@ rtl/pcxrle_pkg.sv @@
// shared types, register indexes and constants of the pcx run-length scan line decoder
package pcxrle_pkg;

    localparam int MAX_BPP_DEF = 256;
    localparam int MAX_LINES   = 4096;

    localparam int CFG_W = 13;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_BPP      = 3'd0;
    localparam logic [IDX_W-1:0] REG_PLANES   = 3'd1;
    localparam logic [IDX_W-1:0] REG_MODE     = 3'd2;
    localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_ORIGIN_X = 3'd4;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 3'd5;

    localparam logic [1:0] MODE_BYTE   = 2'd0;
    localparam logic [1:0] MODE_MONO   = 2'd1;
    localparam logic [1:0] MODE_PLANAR = 2'd2;

    localparam logic [8:0]  RST_BPP      = 9'd80;
    localparam logic [2:0]  RST_PLANES   = 3'd4;
    localparam logic [1:0]  RST_MODE     = MODE_PLANAR;
    localparam logic [12:0] RST_HEIGHT   = 13'd480;
    localparam logic [11:0] RST_ORIGIN_X = 12'd0;
    localparam logic [11:0] RST_ORIGIN_Y = 12'd0;

    localparam logic [7:0] RUN_MARK = 8'hC0;
    localparam logic [7:0] LEN_MASK = 8'h3F;
    localparam logic [3:0] PIX_ON   = 4'd15;
    localparam logic [3:0] CNT_BYTE  = 4'd1;
    localparam logic [3:0] CNT_GROUP = 4'd8;

    typedef struct packed {
        logic [12:0] line_number;
        logic [12:0] first_column;
        logic [3:0]  pixel_count;
        logic [31:0] pixel_values;
        logic        last_of_run;
        logic        image_done;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PLACE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic take;
        logic fetch;
        logic place;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic start_work;
        logic rep_last;
        logic line_end;
        logic made;
        logic hold_valid;
        logic out_free;
    } status_t;

endpackage

@@ rtl/pcxrle_ctrl.sv @@
// control state machine: accepts code bytes and sequences each placement of a run
module pcxrle_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pcxrle_pkg::status_t status,
    output pcxrle_pkg::cmd_t    cmd
);
    import pcxrle_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (status.start_work)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_PLACE;
            end
            ST_PLACE:
            begin
                if (!(status.made && status.hold_valid && !status.out_free))
                begin
                    cmd.place = 1'b1;
                    if (status.line_end || status.rep_last)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!status.hold_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/pcxrle_dpath.sv @@
// datapath: registers, run and line counters, plane store and result registers
module pcxrle_dpath #(
    parameter int MAX_BYTES_PER_PLANE = pcxrle_pkg::MAX_BPP_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pcxrle_pkg::IDX_W-1:0]         cfg_index,
    input  logic [pcxrle_pkg::CFG_W-1:0]         cfg_data,
    input  logic [7:0]                           code_byte,
    input  pcxrle_pkg::cmd_t                     cmd,
    output pcxrle_pkg::status_t                  status,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output pcxrle_pkg::result_t                  out_result
);
    import pcxrle_pkg::*;

    localparam int COL_W = $clog2(MAX_BYTES_PER_PLANE);
    localparam int BPP_W = $clog2(MAX_BYTES_PER_PLANE + 1);
    localparam int POS_W = $clog2(4 * MAX_BYTES_PER_PLANE);
    localparam int TOT_W = $clog2(4 * MAX_BYTES_PER_PLANE + 1);

    logic [8:0]  bpp_reg;
    logic [2:0]  planes_reg;
    logic [1:0]  mode_reg;
    logic [12:0] height_reg;
    logic [11:0] ox_reg;
    logic [11:0] oy_reg;

    logic             run_pending_reg;
    logic [5:0]       run_len_reg;
    logic [5:0]       rep_left_reg;
    logic [POS_W-1:0] pos_reg;
    logic [12:0]      line_reg;
    logic             finished_reg;
    logic [7:0]       byte_reg;

    logic [1:0]       plane_reg;
    logic [COL_W-1:0] col_reg;
    logic [POS_W-1:0] pos_snap_reg;
    logic             line_end_reg;

    logic    hold_valid_reg;
    logic    out_valid_reg;
    result_t hold_reg;
    result_t out_reg;

    logic [BPP_W-1:0] bpp_eff;
    logic [2:0]       planes_eff;
    logic [12:0]      height_eff;
    logic [TOT_W-1:0] m1;
    logic [TOT_W-1:0] m2;
    logic [TOT_W-1:0] m3;
    logic [TOT_W-1:0] m4;
    logic [TOT_W-1:0] total;
    logic [TOT_W-1:0] pos_eff;
    logic [TOT_W-1:0] base;
    logic [1:0]       plane_c;
    logic [COL_W-1:0] col_c;
    logic             line_end_c;

    logic        is_code;
    logic        is_planar;
    logic        made;
    logic        mem_we;
    logic [12:0] line_inc;
    logic        fin_c;
    logic [7:0]  rd_data [3];
    result_t     new_res;
    result_t     flush_res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg    <= RST_BPP;
            planes_reg <= RST_PLANES;
            mode_reg   <= RST_MODE;
            height_reg <= RST_HEIGHT;
            ox_reg     <= RST_ORIGIN_X;
            oy_reg     <= RST_ORIGIN_Y;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BPP:      bpp_reg    <= cfg_data[8:0];
                REG_PLANES:   planes_reg <= cfg_data[2:0];
                REG_MODE:     mode_reg   <= cfg_data[1:0];
                REG_HEIGHT:   height_reg <= cfg_data[12:0];
                REG_ORIGIN_X: ox_reg     <= cfg_data[11:0];
                REG_ORIGIN_Y: oy_reg     <= cfg_data[11:0];
                default:      ;
            endcase
        end
    end

    // saturated register values
    always_comb
    begin
        if (bpp_reg == 9'd0)
            bpp_eff = BPP_W'(1);
        else if (32'(bpp_reg) > MAX_BYTES_PER_PLANE)
            bpp_eff = BPP_W'(MAX_BYTES_PER_PLANE);
        else
            bpp_eff = BPP_W'(bpp_reg);

        if (planes_reg == 3'd0)
            planes_eff = 3'd1;
        else if (planes_reg > 3'd4)
            planes_eff = 3'd4;
        else
            planes_eff = planes_reg;

        if (height_reg == 13'd0)
            height_eff = 13'd1;
        else if (32'(height_reg) > MAX_LINES)
            height_eff = 13'(MAX_LINES);
        else
            height_eff = height_reg;
    end

    // plane and column of the current line position
    always_comb
    begin
        m1 = TOT_W'(bpp_eff);
        m2 = m1 << 1;
        m3 = m2 + m1;
        m4 = m1 << 2;
        case (planes_eff)
            3'd1:    total = m1;
            3'd2:    total = m2;
            3'd3:    total = m3;
            default: total = m4;
        endcase
        pos_eff = (TOT_W'(pos_reg) >= total) ? '0 : TOT_W'(pos_reg);
        if (pos_eff >= m3)
        begin
            plane_c = 2'd3;
            base    = m3;
        end
        else if (pos_eff >= m2)
        begin
            plane_c = 2'd2;
            base    = m2;
        end
        else if (pos_eff >= m1)
        begin
            plane_c = 2'd1;
            base    = m1;
        end
        else
        begin
            plane_c = 2'd0;
            base    = '0;
        end
        col_c      = COL_W'(pos_eff - base);
        line_end_c = (pos_eff + TOT_W'(1)) == total;
    end

    assign is_code   = (code_byte & RUN_MARK) == RUN_MARK;
    assign is_planar = !(mode_reg == MODE_BYTE || mode_reg == MODE_MONO);
    assign made      = is_planar ? (plane_reg == 2'd3) : (plane_reg == 2'd0);
    assign mem_we    = cmd.place && is_planar && (plane_reg != 2'd3);
    assign line_inc  = line_reg + 13'd1;
    assign fin_c     = line_end_reg && (line_inc >= height_eff);

    // run and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_pending_reg <= 1'b0;
            run_len_reg     <= '0;
            rep_left_reg    <= '0;
            pos_reg         <= '0;
            line_reg        <= '0;
            finished_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.take && !finished_reg)
            begin
                if (run_pending_reg)
                begin
                    run_pending_reg <= 1'b0;
                    run_len_reg     <= '0;
                    rep_left_reg    <= run_len_reg;
                end
                else if (is_code)
                begin
                    run_pending_reg <= 1'b1;
                    run_len_reg     <= 6'(code_byte & LEN_MASK);
                end
                else
                begin
                    rep_left_reg <= 6'd1;
                end
            end
            if (cmd.place)
            begin
                rep_left_reg <= rep_left_reg - 6'd1;
                if (line_end_reg)
                begin
                    pos_reg  <= '0;
                    line_reg <= line_inc;
                    if (fin_c)
                    begin
                        finished_reg <= 1'b1;
                    end
                end
                else
                begin
                    pos_reg <= pos_snap_reg + POS_W'(1);
                end
            end
        end
    end

    // byte and position snapshot for the placement
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            byte_reg <= code_byte;
        end
        if (cmd.fetch)
        begin
            plane_reg    <= plane_c;
            col_reg      <= col_c;
            pos_snap_reg <= POS_W'(pos_eff);
            line_end_reg <= line_end_c;
        end
    end

    // plane store, one memory per stored plane
    for (genvar k = 0; k < 3; k++)
    begin : g_plane
        logic [7:0] mem [MAX_BYTES_PER_PLANE];
        logic [7:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (mem_we && plane_reg == 2'(k))
            begin
                mem[col_reg] <= byte_reg;
            end
            if (cmd.fetch)
            begin
                rd_reg <= mem[col_c];
            end
        end

        assign rd_data[k] = rd_reg;
    end

    // pixel group of this placement
    always_comb
    begin
        new_res             = '0;
        new_res.line_number = 13'(oy_reg) + line_reg;
        new_res.image_done  = fin_c;
        new_res.last_of_run = 1'b0;
        if (mode_reg == MODE_BYTE)
        begin
            new_res.first_column = 13'(ox_reg) + 13'(col_reg);
            new_res.pixel_count  = CNT_BYTE;
            new_res.pixel_values = {24'd0, byte_reg};
        end
        else
        begin
            new_res.first_column = 13'(ox_reg) + 13'({col_reg, 3'b000});
            new_res.pixel_count  = CNT_GROUP;
            for (int i = 0; i < 8; i++)
            begin
                if (mode_reg == MODE_MONO)
                    new_res.pixel_values[4*i +: 4] = byte_reg[i] ? PIX_ON : 4'd0;
                else
                    new_res.pixel_values[4*i +: 4] =
                        {byte_reg[i], rd_data[2][i], rd_data[1][i], rd_data[0][i]};
            end
        end
    end

    // held group marked as last of its byte
    always_comb
    begin
        flush_res             = hold_reg;
        flush_res.last_of_run = 1'b1;
    end

    // held result and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.flush || (cmd.place && made && hold_valid_reg))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.place && made)
            begin
                hold_valid_reg <= 1'b1;
            end
            if (cmd.flush)
            begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.place && made)
        begin
            hold_reg <= new_res;
            if (hold_valid_reg)
            begin
                out_reg <= hold_reg;
            end
        end
        if (cmd.flush)
        begin
            out_reg <= flush_res;
        end
    end

    always_comb
    begin
        status.start_work = !finished_reg &&
                            (run_pending_reg ? (run_len_reg != 6'd0) : !is_code);
        status.rep_last   = rep_left_reg == 6'd1;
        status.line_end   = line_end_reg;
        status.made       = made;
        status.hold_valid = hold_valid_reg;
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

@@ rtl/pcx_rle_scanline_decoder_core.sv @@
// top level of the pcx run-length scan line decoder
//
// code bytes enter on in_valid/in_ready, one per transaction; pixel groups leave
// on out_valid/out_ready, one per transaction. registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no
// transaction is in progress, as the block does not enforce this. a byte is
// taken in the idle state; every decoded byte placed in the line then goes
// through a plane store read and then its placement; the registered plane
// store read is what sets this read step. a group goes out once the next
// group of its byte or the end of the byte's run or line is known, so the
// first group of a byte passes the hold register before the output register.
// a stalled receiver holds one group in the output register and one more
// held internally; decoding then waits. run count bytes and bytes after the
// final line give no result and leave in_ready high.
// reset restores the register defaults and clears run, line and done state;
// the plane store holds no reset value and needs no clearing pass.
module pcx_rle_scanline_decoder_core #(
    parameter int MAX_BYTES_PER_PLANE = pcxrle_pkg::MAX_BPP_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [pcxrle_pkg::IDX_W-1:0] cfg_index,
    input  logic [pcxrle_pkg::CFG_W-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   code_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [12:0]                  line_number,
    output logic [12:0]                  first_column,
    output logic [3:0]                   pixel_count,
    output logic [31:0]                  pixel_values,
    output logic                         last_of_run,
    output logic                         image_done
);
    import pcxrle_pkg::*;

    cmd_t    cmd;
    status_t status;
    result_t out_result;

    pcxrle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pcxrle_dpath #(
        .MAX_BYTES_PER_PLANE (MAX_BYTES_PER_PLANE)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .code_byte  (code_byte),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_result (out_result)
    );

    assign line_number  = out_result.line_number;
    assign first_column = out_result.first_column;
    assign pixel_count  = out_result.pixel_count;
    assign pixel_values = out_result.pixel_values;
    assign last_of_run  = out_result.last_of_run;
    assign image_done   = out_result.image_done;

endmodule

@@ rtl/pcxrle_chk.sv @@
// port checker for the pcx run-length scan line decoder and its bind
module pcxrle_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  pixel_count,
    input logic [31:0] pixel_values,
    input logic        last_of_run,
    input logic        image_done
);
    import pcxrle_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output transaction dropped while stalled");

    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pixel_count == CNT_BYTE || pixel_count == CNT_GROUP))
        else $error("illegal pixel count");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_done |-> last_of_run)
        else $error("image done on a group that is not last of its byte");

    a_byte_upper: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_count == CNT_BYTE |-> pixel_values[31:8] == 24'd0)
        else $error("eight-bit pixel with upper bits set");

endmodule

bind pcx_rle_scanline_decoder_core pcxrle_chk u_chk (.*);
